[rtl/rtph_pkg.sv]
package rtph_pkg;

    localparam int MTU_BYTES         = 1500;
    localparam int FRAME_LENGTH_BITS = 24;
    localparam int QDEPTH            = 4;
    localparam int QPTR_W            = $clog2(QDEPTH);

    // configuration register indexes
    localparam logic CFG_SSRC  = 1'b0;
    localparam logic CFG_CODEC = 1'b1;

    // payload bytes per fragment, per codec
    localparam logic [15:0] MAXP_H264 = 16'(MTU_BYTES - 16 - 2);
    localparam logic [15:0] MAXP_H265 = 16'(MTU_BYTES - 16 - 3);

    // capture gap_ms = floor(diff/1000) by reciprocal multiply; 40 if over
    localparam logic [63:0] GAP_LIMIT_US = 64'd2001000;
    localparam logic [20:0] GAP_CLAMP_US = 21'd40000;
    localparam logic [21:0] RECIP_1000   = 22'd2147484;  // ceil(2^31 / 1000)
    localparam int          RECIP_SHIFT  = 31;
    localparam logic [6:0]  TICKS_PER_MS = 7'd90;

    // header phase codes
    localparam logic [2:0] PH_SC0  = 3'd0;
    localparam logic [2:0] PH_SC1  = 3'd1;
    localparam logic [2:0] PH_SC2  = 3'd2;
    localparam logic [2:0] PH_SC3  = 3'd3;
    localparam logic [2:0] PH_NAL0 = 3'd4;
    localparam logic [2:0] PH_NAL1 = 3'd5;
    localparam logic [2:0] PH_SNGL = 3'd6;
    localparam logic [2:0] PH_FRAG = 3'd7;

    // command kinds
    localparam logic [1:0] K_ERR  = 2'd0;
    localparam logic [1:0] K_DATA = 2'd1;
    localparam logic [1:0] K_PKT  = 2'd2;

    localparam logic [4:0] HDR_BYTES = 5'd16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic        pend;
        logic [15:0] rtp_len;
        logic        marker;
        logic        h265;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [1:0]  nfu;
        logic [7:0]  fu0;
        logic [7:0]  fu1;
        logic [7:0]  fu2;
    } t_cmd;

endpackage

[rtl/rtph_front.sv]
module rtph_front import rtph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_first,
    input  logic [23:0] i_frame_length,
    input  logic [63:0] i_capture_time_us,
    input  logic        i_codec,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [15:0] r_seq, n_seq;
    logic [31:0] r_ts, n_ts;
    logic [63:0] r_prev;
    logic [FRAME_LENGTH_BITS-1:0] r_bl, n_bl, bl_dec;
    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_nalh, n_nalh;
    logic [10:0] r_fsent, n_fsent, fsent_inc;
    logic        r_fmode, n_fmode;
    logic        r_ffirst, n_ffirst;
    logic        r_drop, n_drop;
    logic        r_codec, n_codec;
    logic [20:0] r_gapx;
    logic [42:0] r_prod;

    logic [63:0] diff;
    logic [10:0] gap;
    logic [31:0] step;
    logic [15:0] maxp, cur;
    logic [FRAME_LENGTH_BITS:0] rem;
    logic        last, fend, skip;
    logic [7:0]  b0, flags;

    // timestamp step pipeline: r_gapx is registered on a frame's first byte, then r_prod;
    // step is ready before the frame's start code can complete
    assign diff = i_capture_time_us - r_prev;
    assign gap  = r_prod[RECIP_SHIFT +: 11];
    assign step = 32'(gap * TICKS_PER_MS);

    always_comb begin
        n_seq    = r_seq;
        n_ts     = r_ts;
        n_bl     = r_bl;
        n_phase  = r_phase;
        n_nalh   = r_nalh;
        n_fsent  = r_fsent;
        n_fmode  = r_fmode;
        n_ffirst = r_ffirst;
        n_drop   = r_drop;
        n_codec  = r_codec;
        o_push   = 1'b0;
        o_cmd    = '0;
        bl_dec   = '0;
        fsent_inc = '0;
        maxp = '0;
        cur  = '0;
        rem  = '0;
        last = 1'b0;
        fend = 1'b0;
        skip = 1'b0;
        b0   = '0;
        flags = '0;
        if (i_valid) begin
            if (i_frame_first) begin
                n_codec  = i_codec;
                n_phase  = PH_SC0;
                n_nalh   = '0;
                n_fsent  = '0;
                n_fmode  = 1'b0;
                n_ffirst = 1'b1;
                n_drop   = 1'b0;
                n_bl     = i_frame_length[FRAME_LENGTH_BITS-1:0];
                if (i_frame_length[FRAME_LENGTH_BITS-1:0] < FRAME_LENGTH_BITS'(4)) begin
                    o_push     = 1'b1;
                    o_cmd.kind = K_ERR;
                    n_drop     = 1'b1;
                    n_bl       = '0;
                    skip       = 1'b1;
                end
            end
            if (!skip && !n_drop && n_bl != '0) begin
                bl_dec = n_bl - 1'b1;
                n_bl   = bl_dec;
                case (n_phase)
                    PH_SC0, PH_SC1: begin
                        if (i_frame_byte != 8'h00) begin
                            o_push = 1'b1; o_cmd.kind = K_ERR;
                            n_drop = 1'b1; n_bl = '0;
                        end else begin
                            n_phase = n_phase + 3'd1;
                        end
                    end
                    PH_SC2, PH_SC3: begin
                        if (i_frame_byte == 8'h01) begin
                            if (bl_dec == '0) begin
                                o_push = 1'b1; o_cmd.kind = K_ERR;
                                n_drop = 1'b1; n_bl = '0;
                            end else begin
                                n_ts     = r_ts + step;
                                n_fmode  = (32'(bl_dec) + 32'd16) > 32'(MTU_BYTES);
                                n_fsent  = '0;
                                n_ffirst = 1'b1;
                                n_phase  = PH_NAL0;
                            end
                        end else if (i_frame_byte == 8'h00 && n_phase == PH_SC2) begin
                            n_phase = PH_SC3;
                        end else begin
                            o_push = 1'b1; o_cmd.kind = K_ERR;
                            n_drop = 1'b1; n_bl = '0;
                        end
                    end
                    PH_NAL0: begin
                        if (!n_fmode) begin
                            o_push        = 1'b1;
                            o_cmd.kind    = K_PKT;
                            o_cmd.rtp_len = 16'(bl_dec) + 16'd13;
                            o_cmd.marker  = 1'b1;
                            o_cmd.h265    = n_codec;
                            o_cmd.seq     = r_seq;
                            o_cmd.ts      = r_ts;
                            o_cmd.payload = i_frame_byte;
                            o_cmd.pend    = (bl_dec == '0);
                            n_seq         = r_seq + 16'd1;
                            n_phase       = PH_SNGL;
                        end else begin
                            n_nalh  = {i_frame_byte, 8'h00};
                            n_phase = n_codec ? PH_NAL1 : PH_FRAG;
                        end
                    end
                    PH_NAL1: begin
                        n_nalh  = {n_nalh[15:8], i_frame_byte};
                        n_phase = PH_FRAG;
                    end
                    PH_SNGL: begin
                        o_push        = 1'b1;
                        o_cmd.kind    = K_DATA;
                        o_cmd.payload = i_frame_byte;
                        o_cmd.pend    = (bl_dec == '0);
                    end
                    default: begin
                        maxp  = n_codec ? MAXP_H265 : MAXP_H264;
                        rem   = {1'b0, bl_dec} + 1'b1;
                        last  = rem <= (FRAME_LENGTH_BITS+1)'(maxp);
                        cur   = last ? 16'(rem) : maxp;
                        b0    = n_nalh[15:8];
                        flags = {n_ffirst, last, 6'd0};
                        o_push        = 1'b1;
                        o_cmd.payload = i_frame_byte;
                        if (n_fsent == '0) begin
                            o_cmd.kind    = K_PKT;
                            o_cmd.marker  = last;
                            o_cmd.h265    = n_codec;
                            o_cmd.seq     = r_seq;
                            o_cmd.ts      = r_ts;
                            n_seq         = r_seq + 16'd1;
                            n_ffirst      = 1'b0;
                            if (n_codec) begin
                                o_cmd.rtp_len = cur + 16'd15;
                                o_cmd.nfu     = 2'd3;
                                o_cmd.fu0     = (b0 & 8'h81) | 8'(49 << 1);
                                o_cmd.fu1     = n_nalh[7:0];
                                o_cmd.fu2     = flags | ((b0 & 8'h7E) >> 1);
                            end else begin
                                o_cmd.rtp_len = cur + 16'd14;
                                o_cmd.nfu     = 2'd2;
                                o_cmd.fu0     = (b0 & 8'hE0) | 8'd28;
                                o_cmd.fu1     = flags | (b0 & 8'h1F);
                            end
                        end else begin
                            o_cmd.kind = K_DATA;
                        end
                        fsent_inc  = n_fsent + 11'd1;
                        fend       = (16'(fsent_inc) >= maxp) || (bl_dec == '0);
                        o_cmd.pend = fend;
                        n_fsent    = fend ? 11'd0 : fsent_inc;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= '0;
            r_ts     <= '0;
            r_prev   <= '0;
            r_bl     <= '0;
            r_phase  <= PH_SC0;
            r_nalh   <= '0;
            r_fsent  <= '0;
            r_fmode  <= 1'b0;
            r_ffirst <= 1'b1;
            r_drop   <= 1'b0;
            r_codec  <= 1'b0;
            r_gapx   <= '0;
            r_prod   <= '0;
        end else begin
            r_seq    <= n_seq;
            r_ts     <= n_ts;
            r_bl     <= n_bl;
            r_phase  <= n_phase;
            r_nalh   <= n_nalh;
            r_fsent  <= n_fsent;
            r_fmode  <= n_fmode;
            r_ffirst <= n_ffirst;
            r_drop   <= n_drop;
            r_codec  <= n_codec;
            if (i_valid && i_frame_first) begin
                r_prev <= i_capture_time_us;
                r_gapx <= (diff >= GAP_LIMIT_US) ? GAP_CLAMP_US : diff[20:0];
            end
            r_prod <= r_gapx * RECIP_1000;
        end
    end

endmodule

[rtl/rtph_fifo.sv]
module rtph_fifo import rtph_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
        end
    end

endmodule

[rtl/rtph_back.sv]
module rtph_back import rtph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  logic        i_q_empty,
    input  logic        i_pop,
    input  logic [31:0] i_ssrc,
    output logic        o_q_pop,
    output logic [7:0]  o_out_byte,
    output logic        o_packet_end,
    output logic        o_frame_error,
    output logic        o_run_last
);

    logic [4:0] r_idx;
    logic [4:0] last_idx, fu_off;
    logic       is_pkt, take;

    assign is_pkt   = (i_head.kind == K_PKT);
    assign last_idx = is_pkt ? (HDR_BYTES + 5'(i_head.nfu)) : 5'd0;
    assign fu_off   = r_idx - HDR_BYTES;
    assign take     = i_pop && !i_q_empty;

    assign o_run_last    = (r_idx == last_idx);
    assign o_q_pop       = take && o_run_last;
    assign o_frame_error = (i_head.kind == K_ERR);
    assign o_packet_end  = o_run_last && i_head.pend && !o_frame_error;

    always_comb begin
        if (!is_pkt || o_run_last) begin
            o_out_byte = o_frame_error ? 8'h00 : i_head.payload;
        end else begin
            case (r_idx)
                5'd0:  o_out_byte = 8'h24;
                5'd1:  o_out_byte = 8'h00;
                5'd2:  o_out_byte = i_head.rtp_len[15:8];
                5'd3:  o_out_byte = i_head.rtp_len[7:0];
                5'd4:  o_out_byte = 8'h80;
                5'd5:  o_out_byte = {i_head.marker, i_head.h265 ? 7'd98 : 7'd96};
                5'd6:  o_out_byte = i_head.seq[15:8];
                5'd7:  o_out_byte = i_head.seq[7:0];
                5'd8:  o_out_byte = i_head.ts[31:24];
                5'd9:  o_out_byte = i_head.ts[23:16];
                5'd10: o_out_byte = i_head.ts[15:8];
                5'd11: o_out_byte = i_head.ts[7:0];
                5'd12: o_out_byte = i_ssrc[31:24];
                5'd13: o_out_byte = i_ssrc[23:16];
                5'd14: o_out_byte = i_ssrc[15:8];
                5'd15: o_out_byte = i_ssrc[7:0];
                default: begin
                    case (fu_off[1:0])
                        2'd0:    o_out_byte = i_head.fu0;
                        2'd1:    o_out_byte = i_head.fu1;
                        default: o_out_byte = i_head.fu2;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= o_run_last ? 5'd0 : r_idx + 5'd1;
        end
    end

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_empty |-> r_idx == '0)
        else $error("byte index moved with no command queued");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_q_empty && o_frame_error) |-> (o_out_byte == 8'h00 && !o_packet_end && o_run_last))
        else $error("error transaction carries data");

    a_hold_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_run_last) |=> !i_q_empty)
        else $error("command left the queue before all bytes went out");

    a_pkt_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_q_empty && !is_pkt) |-> r_idx == '0)
        else $error("single-byte command with nonzero index");

endmodule

[rtl/rtp_h26x_packetizer_top.sv]
// RTP packetizer for Annex-B H.264/H.265 frames, RTSP-interleaved framing. Feed one frame
// byte per transaction; frame_length and capture_time_us are sampled with frame_first.
// Each input byte is taken in one cycle; a byte that opens a packet produces 17 to 20
// result bytes (interleave header, RTP header, FU bytes, payload), which drain one per
// cycle from a 4-entry command queue, so the input stalls (full) while those header
// bursts drain or while pop is held low and the queue has filled. run_last marks the
// final byte of each queued command. Write ssrc and codec_select only while the block is
// idle; codec_select takes effect on the next frame.
module rtp_h26x_packetizer_top import rtph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_first,
    input  logic [23:0] i_frame_length,
    input  logic [63:0] i_capture_time_us,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_packet_end,
    output logic        o_frame_error,
    output logic        o_run_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    logic [31:0] r_ssrc;
    logic        r_codec;
    logic        accept, cmd_push, q_pop;
    t_cmd        cmd, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssrc  <= '0;
            r_codec <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SSRC:  r_ssrc  <= i_cfg_wdata;
                CFG_CODEC: r_codec <= i_cfg_wdata[0];
                default:   r_ssrc  <= r_ssrc;
            endcase
        end
    end

    assign accept = push && !full;

    rtph_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (accept),
        .i_frame_byte      (i_frame_byte),
        .i_frame_first     (i_frame_first),
        .i_frame_length    (i_frame_length),
        .i_capture_time_us (i_capture_time_us),
        .i_codec           (r_codec),
        .o_push            (cmd_push),
        .o_cmd             (cmd)
    );

    rtph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    rtph_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_empty     (empty),
        .i_pop         (pop),
        .i_ssrc        (r_ssrc),
        .o_q_pop       (q_pop),
        .o_out_byte    (o_out_byte),
        .o_packet_end  (o_packet_end),
        .o_frame_error (o_frame_error),
        .o_run_last    (o_run_last)
    );

endmodule
